[hw/rtl/pperl_pkg.sv]
// Shared types and codes for the per-player event rate limiter.
package pperl_pkg;

   localparam int TICK_W = 64;

   typedef logic [TICK_W-1:0] tick_type;

   // item kinds
   typedef enum logic [1:0] {
      KIND_ATTEMPT = 2'd0,
      KIND_QUERY   = 2'd1,
      KIND_SUCCESS = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic [1:0] CSR_INITIAL_DELAY  = 2'd0;
   localparam logic [1:0] CSR_CHECK_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_MINIMUM_GAP    = 2'd2;

   // shared adder operation
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // adder result: carry is overflow on add, a >= b on subtract
   typedef struct packed {
      logic     carry;
      tick_type sum;
      tick_type sat;
   } alu_res_type;

   // table port controls
   typedef struct packed {
      logic rd_en;
      logic rec_we;
      logic cool_we;
      logic clear_all;
   } tbl_ctl_type;

endpackage

[hw/rtl/pperl_alu.sv]
// Shared 64-bit add / compare unit with saturation.
module pperl_alu import pperl_pkg::*; (
   input  tick_type    a,
   input  tick_type    b,
   input  alu_op_type  op,
   output alu_res_type res
);

   logic [TICK_W:0] sum_wide;
   tick_type        b_eff;

   // subtract as a + ~b + 1, carry out means no borrow
   always_comb begin
      b_eff    = (op == ALU_SUB) ? ~b : b;
      sum_wide = {1'b0, a} + {1'b0, b_eff} + {{TICK_W{1'b0}}, (op == ALU_SUB)};
      res.carry = sum_wide[TICK_W];
      res.sum   = sum_wide[TICK_W-1:0];
      res.sat   = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
   end

endmodule

[hw/rtl/pperl_table.sv]
// Player entry table: present bits, entry record memory, cooldown memory.
module pperl_table import pperl_pkg::*; #(
   parameter int ENTRIES   = 256,
   parameter int DEF_SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tbl_ctl_type                        ctl,
   input  logic [$clog2(ENTRIES)-1:0]         rd_pidx,
   input  logic [((DEF_SLOTS > 1) ? $clog2(DEF_SLOTS) : 1)-1:0] rd_didx,
   input  logic [$clog2(ENTRIES)-1:0]         wr_pidx,
   input  logic [((DEF_SLOTS > 1) ? $clog2(DEF_SLOTS) : 1)-1:0] wr_didx,
   input  logic [3*TICK_W+DEF_SLOTS-1:0]      wr_rec,
   input  tick_type                           wr_cool,
   output logic [3*TICK_W+DEF_SLOTS-1:0]      rd_rec,
   output tick_type                           rd_cool,
   output logic                               rd_present
);

   localparam int DIDX_W = (DEF_SLOTS > 1) ? $clog2(DEF_SLOTS) : 1;
   localparam int REC_W  = 3*TICK_W + DEF_SLOTS;
   localparam int COOL_DEPTH = ENTRIES << DIDX_W;

   logic [REC_W-1:0]  rec_mem [ENTRIES];
   tick_type          cool_mem [COOL_DEPTH];
   logic [ENTRIES-1:0] present_ff;
   logic [REC_W-1:0]  rd_rec_ff;
   tick_type          rd_cool_ff;
   logic              rd_present_ff;

   // entry record memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.rec_we) begin
         rec_mem[wr_pidx] <= wr_rec;
      end
      if (ctl.rd_en) begin
         rd_rec_ff     <= rec_mem[rd_pidx];
         rd_present_ff <= present_ff[rd_pidx];
      end
   end

   // cooldown deadline memory, addressed by player and definition
   always_ff @(posedge clock) begin
      if (ctl.cool_we) begin
         cool_mem[{wr_pidx, wr_didx}] <= wr_cool;
      end
      if (ctl.rd_en) begin
         rd_cool_ff <= cool_mem[{rd_pidx, rd_didx}];
      end
   end

   // present bits: cleared at once by reset or a clear word
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (ctl.clear_all) begin
         present_ff <= '0;
      end else if (ctl.rec_we) begin
         present_ff[wr_pidx] <= 1'b1;
      end
   end

   assign rd_rec     = rd_rec_ff;
   assign rd_cool    = rd_cool_ff;
   assign rd_present = rd_present_ff;

endmodule

[hw/rtl/per_player_event_rate_limiter_unit.sv]
// Per-player event rate limiter: top level with step sequencer.
// One word at a time through one shared 64-bit adder, one adder step per cycle.
// Adder steps: clear or ignored player none; query a compare; success a gap add,
// then a cooldown add if set; attempt (none for player zero) up to two deadline
// compares, increment, reschedule add. A stalled result holds the next word off.
// Reset: synchronous; present bits clear, no memory sweep; control regs go to 0.
module per_player_event_rate_limiter_unit import pperl_pkg::*; #(
   parameter int PLAYER_SLOTS     = 256,
   parameter int DEFINITION_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_player,
   input  logic [3:0]  req_definition,
   input  logic        req_definition_present,
   input  logic [63:0] req_repeat_cooldown,
   input  logic [63:0] req_current_tick,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_attempt_granted,
   output logic [63:0] rsp_attempt_number,
   output logic        rsp_on_cooldown,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int ENTRIES = (PLAYER_SLOTS < 256) ? PLAYER_SLOTS : 256;
   localparam int PIDX_W  = $clog2(ENTRIES);
   localparam int DIDX_W  = (DEFINITION_SLOTS > 1) ? $clog2(DEFINITION_SLOTS) : 1;
   localparam int REC_W   = 3*TICK_W + DEFINITION_SLOTS;
   // record layout: {next_check, next_allowed, count, cooldown_valid}
   localparam int NC_HI  = REC_W - 1;
   localparam int NA_HI  = REC_W - 1 - TICK_W;
   localparam int CNT_HI = REC_W - 1 - 2*TICK_W;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_CHK_NC, S_CHK_NA, S_INC, S_ADD_NC,
      S_GAP, S_COOL, S_QCMP, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration
   tick_type idelay_ff, intv_ff, gap_ff;

   // latched word
   kind_type    kind_ff, kind_in;
   logic [7:0]  player_ff, player_in;
   logic [3:0]  def_ff, def_in;
   logic        dpres_ff, dpres_in;
   tick_type    rc_ff, rc_in;
   tick_type    now_ff, now_in;

   // working copy of the entry
   tick_type    nc_ff, nc_in;
   tick_type    na_ff, na_in;
   tick_type    cnt_ff, cnt_in;
   logic [DEFINITION_SLOTS-1:0] cv_ff, cv_in;
   tick_type    cu_ff, cu_in;
   logic        present_ff, present_in;

   // result being built
   logic        gr_ff, gr_in;
   tick_type    num_ff, num_in;
   logic        cool_ff, cool_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_gr_ff, rsp_gr_in;
   tick_type    rsp_num_ff, rsp_num_in;
   logic        rsp_cool_ff, rsp_cool_in;

   // table and adder hookup
   tbl_ctl_type              tbl_ctl;
   logic [PIDX_W-1:0]        rd_pidx, pidx;
   logic [DIDX_W-1:0]        rd_didx, didx;
   logic [REC_W-1:0]         wr_rec, rd_rec;
   logic [DEFINITION_SLOTS-1:0] wr_cv;
   tick_type                 wr_nc, wr_na, rd_cool;
   logic                     rd_present;
   tick_type                 alu_a, alu_b;
   alu_op_type               alu_op;
   alu_res_type              alu_res;

   logic player_ok, dok;

   assign player_ok = (32'(player_ff) < ENTRIES);
   assign dok       = dpres_ff && (32'(def_ff) < DEFINITION_SLOTS);
   assign pidx      = PIDX_W'(player_ff);
   assign didx      = DIDX_W'(def_ff);
   assign rd_pidx   = PIDX_W'(req_player);
   assign rd_didx   = DIDX_W'(req_definition);

   // write-back record
   always_comb begin
      wr_nc = (state_ff == S_ADD_NC) ? alu_res.sat : nc_ff;
      wr_na = (state_ff == S_GAP) ? alu_res.sat : na_ff;
      wr_cv = cv_ff;
      if (state_ff == S_COOL) begin
         wr_cv[didx] = 1'b1;
      end
      wr_rec = {wr_nc, wr_na, cnt_ff, wr_cv};
   end

   pperl_table #(
      .ENTRIES   (ENTRIES),
      .DEF_SLOTS (DEFINITION_SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .rd_pidx    (rd_pidx),
      .rd_didx    (rd_didx),
      .wr_pidx    (pidx),
      .wr_didx    (didx),
      .wr_rec     (wr_rec),
      .wr_cool    (alu_res.sat),
      .rd_rec     (rd_rec),
      .rd_cool    (rd_cool),
      .rd_present (rd_present)
   );

   // operand select for the shared adder
   always_comb begin
      alu_a  = now_ff;
      alu_b  = '0;
      alu_op = ALU_ADD;
      case (state_ff)
         S_CHK_NC: begin alu_b = nc_ff; alu_op = ALU_SUB; end
         S_CHK_NA: begin alu_b = na_ff; alu_op = ALU_SUB; end
         S_INC:    begin alu_a = cnt_ff; alu_b = tick_type'(1); end
         S_ADD_NC: alu_b = intv_ff;
         S_GAP:    alu_b = gap_ff;
         S_COOL:   alu_b = rc_ff;
         S_QCMP:   begin alu_b = cu_ff; alu_op = ALU_SUB; end
         default:  alu_b = '0;
      endcase
   end

   pperl_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .op  (alu_op),
      .res (alu_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      player_in    = player_ff;
      def_in       = def_ff;
      dpres_in     = dpres_ff;
      rc_in        = rc_ff;
      now_in       = now_ff;
      nc_in        = nc_ff;
      na_in        = na_ff;
      cnt_in       = cnt_ff;
      cv_in        = cv_ff;
      cu_in        = cu_ff;
      present_in   = present_ff;
      gr_in        = gr_ff;
      num_in       = num_ff;
      cool_in      = cool_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_gr_in    = rsp_gr_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_cool_in  = rsp_cool_ff;
      tbl_ctl      = '0;

      // output taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in     = kind_type'(req_kind);
               player_in   = req_player;
               def_in      = req_definition;
               dpres_in    = req_definition_present;
               rc_in       = req_repeat_cooldown;
               now_in      = req_current_tick;
               tbl_ctl.rd_en = 1'b1;
               tbl_ctl.clear_all = (kind_type'(req_kind) == KIND_CLEAR);
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            gr_in      = 1'b0;
            num_in     = '0;
            cool_in    = 1'b0;
            present_in = rd_present;
            cu_in      = rd_cool;
            // a missing entry starts from its creation values
            if (rd_present) begin
               nc_in  = rd_rec[NC_HI -: TICK_W];
               na_in  = rd_rec[NA_HI -: TICK_W];
               cnt_in = rd_rec[CNT_HI -: TICK_W];
               cv_in  = rd_rec[DEFINITION_SLOTS-1:0];
            end else begin
               nc_in  = idelay_ff;
               na_in  = '0;
               cnt_in = '0;
               cv_in  = '0;
            end
            if (!player_ok) begin
               state_in = S_DONE;
            end else begin
               unique case (kind_ff)
                  KIND_ATTEMPT: state_in = (player_ff == 8'd0) ? S_DONE : S_CHK_NC;
                  KIND_QUERY:   state_in = S_QCMP;
                  KIND_SUCCESS: state_in = S_GAP;
                  KIND_CLEAR:   state_in = S_DONE;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_CHK_NC: begin
            // now below next check: refused, entry still created
            if (!alu_res.carry) begin
               tbl_ctl.rec_we = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_CHK_NA;
            end
         end
         S_CHK_NA: begin
            if (!alu_res.carry) begin
               tbl_ctl.rec_we = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_INC;
            end
         end
         S_INC: begin
            // carry out means the counter is at its maximum
            if (alu_res.carry) begin
               tbl_ctl.rec_we = 1'b1;
               state_in = S_DONE;
            end else begin
               cnt_in   = alu_res.sum;
               state_in = S_ADD_NC;
            end
         end
         S_ADD_NC: begin
            nc_in   = alu_res.sat;
            gr_in   = 1'b1;
            num_in  = cnt_ff;
            tbl_ctl.rec_we = 1'b1;
            state_in = S_DONE;
         end
         S_GAP: begin
            na_in = alu_res.sat;
            if (dok && (rc_ff != '0)) begin
               state_in = S_COOL;
            end else begin
               tbl_ctl.rec_we = 1'b1;
               state_in = S_DONE;
            end
         end
         S_COOL: begin
            cv_in[didx] = 1'b1;
            tbl_ctl.rec_we  = 1'b1;
            tbl_ctl.cool_we = 1'b1;
            state_in = S_DONE;
         end
         S_QCMP: begin
            cool_in  = present_ff && dok && cv_ff[didx] && !alu_res.carry;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_gr_in    = gr_ff;
               rsp_num_in   = num_ff;
               rsp_cool_in  = cool_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      player_ff   <= player_in;
      def_ff      <= def_in;
      dpres_ff    <= dpres_in;
      rc_ff       <= rc_in;
      now_ff      <= now_in;
      nc_ff       <= nc_in;
      na_ff       <= na_in;
      cnt_ff      <= cnt_in;
      cv_ff       <= cv_in;
      cu_ff       <= cu_in;
      present_ff  <= present_in;
      gr_ff       <= gr_in;
      num_ff      <= num_in;
      cool_ff     <= cool_in;
      rsp_gr_ff   <= rsp_gr_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_cool_ff <= rsp_cool_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idelay_ff <= '0;
         intv_ff   <= '0;
         gap_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INITIAL_DELAY:  idelay_ff <= csr_data;
            CSR_CHECK_INTERVAL: intv_ff   <= csr_data;
            CSR_MINIMUM_GAP:    gap_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready           = 1'b1;
   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_attempt_granted = rsp_gr_ff;
   assign rsp_attempt_number  = rsp_num_ff;
   assign rsp_on_cooldown     = rsp_cool_ff;

endmodule
